// ===== hw/rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the run-length sprite row decoder
// Holds the decode codes, the byte phase encoding, the clamp limits and the
// structs passed between the decoder, the result queue and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

   // clamp limits for the image size registers
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W  = 11;
   localparam int ADDR_W = 20;

   // column and row counters saturate here
   localparam logic [COL_W-1:0] COL_MAX = 11'd2047;

   // shadow fill key colors
   localparam logic [15:0] KEY_RGB555 = 16'h7c1f;
   localparam logic [15:0] KEY_RGB565 = 16'hf81f;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DECODE_MODE  = 2'd0;
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd3;

   typedef enum logic [1:0] {
      MODE_COLOR16 = 2'd0,
      MODE_INDEXED = 2'd1,
      MODE_SHADOW  = 2'd2,
      MODE_RAW     = 2'd3
   } decode_mode_type;

   // byte phase: control low, control high, pixel low, pixel high
   typedef enum logic [3:0] {
      PH_CTRL_LO = 4'b0001,
      PH_CTRL_HI = 4'b0010,
      PH_PIX_LO  = 4'b0100,
      PH_PIX_HI  = 4'b1000
   } phase_type;

   typedef struct packed {
      decode_mode_type  mode;
      logic             pix_fmt;
      logic [COL_W-1:0] width;
      logic [COL_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic [7:0]        held;
      logic [COL_W-1:0]  column;
      logic [COL_W-1:0]  row;
      logic [ADDR_W-1:0] row_base;
      logic [7:0]        run_rem;
      logic              line_end;
      logic              finished;
   } dec_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [7:0]        len;
      logic [15:0]       pix;
      logic              done;
      logic              ovf;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_sprite_row_decoder.sv =====
// A result item is registered in the result queue when its stream byte is accepted.
// Throughput: one stream byte per cycle while req_tready is high; a byte that ends
//   the image after a write gives two results, sent one per beat on the result port.
// req_tready is high while the four-entry result queue has room for two items.
// Reset (synchronous, active high) restores register defaults, clears the decoder
//   state and empties the result queue.
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder: run-length sprite row decoder
// Decodes a sprite byte stream into frame-buffer run writes with skip counts,
// end-of-line control words, shadow fill and raw palette copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_row_decoder
   import rsd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // stream input
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] stream_byte
   input  wire  [0:0]  req_tuser,   // [0] image_start
   // results
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [19:0] write_address, [27:20] run_length,
                                    // [43:28] pixel_value, [47:44] zero
   output logic [1:0]  rsp_tuser,   // [0] image_done, [1] overflow
   output logic        rsp_tlast,
   // configuration writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_addr,
   input  wire  [10:0] csr_data
);

   cfg_type       cfg_ff;
   dec_state_type state_ff, state_in;
   rsp_item_type  res0, res1, out_item;
   logic [1:0]    res_cnt;
   logic [1:0]    push_cnt;
   logic          room_ok;
   logic          accept;

   assign req_tready = room_ok;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_COLOR16;
         cfg_ff.pix_fmt <= 1'b0;
         cfg_ff.width   <= 11'd1;
         cfg_ff.height  <= 11'd1;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_DECODE_MODE:  cfg_ff.mode    <= decode_mode_type'(csr_data[1:0]);
            CSR_PIXEL_FORMAT: cfg_ff.pix_fmt <= csr_data[0];
            CSR_IMAGE_WIDTH:  cfg_ff.width   <= csr_data;
            CSR_IMAGE_HEIGHT: cfg_ff.height  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // decode step
   rsd_decode u_decode (
      .cfg         (cfg_ff),
      .state_cur   (state_ff),
      .stream_byte (req_tdata),
      .image_start (req_tuser[0]),
      .state_nxt   (state_in),
      .res0        (res0),
      .res1        (res1),
      .res_cnt     (res_cnt)
   );

   // decoder state advances on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= PH_CTRL_LO;
         state_ff.held     <= '0;
         state_ff.column   <= '0;
         state_ff.row      <= '0;
         state_ff.row_base <= '0;
         state_ff.run_rem  <= '0;
         state_ff.line_end <= 1'b0;
         state_ff.finished <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign push_cnt = accept ? res_cnt : 2'd0;

   // result queue
   rsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (res0),
      .push1     (res1),
      .room_ok   (room_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // result beat packing
   assign rsp_tdata = {4'b0, out_item.pix, out_item.len, out_item.addr};
   assign rsp_tuser = {out_item.ovf, out_item.done};
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_decode.sv =====
// ----------------------------------------------------------------------------
// rsd_decode: per-byte decode step
// Takes the current decoder state, the configuration and one stream byte and
// gives the next state and up to two result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_decode
   import rsd_pkg::*;
(
   input  wire cfg_type       cfg,
   input  wire dec_state_type state_cur,
   input  wire [7:0]          stream_byte,
   input  wire                image_start,
   output dec_state_type      state_nxt,
   output rsp_item_type       res0,
   output rsp_item_type       res1,
   output logic [1:0]         res_cnt
);

   localparam int WIDTH_CAP  = (MAX_WIDTH  > 2047) ? 2047 : MAX_WIDTH;
   localparam int HEIGHT_CAP = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;

   logic [COL_W-1:0] eff_w;
   logic [COL_W-1:0] eff_h;

   // clamp width and height to their legal ranges
   always_comb begin
      if (cfg.width == '0) begin
         eff_w = 11'd1;
      end else if (int'(cfg.width) > WIDTH_CAP) begin
         eff_w = COL_W'(WIDTH_CAP);
      end else begin
         eff_w = cfg.width;
      end
      if (cfg.height == '0) begin
         eff_h = 11'd1;
      end else if (int'(cfg.height) > HEIGHT_CAP) begin
         eff_h = COL_W'(HEIGHT_CAP);
      end else begin
         eff_h = cfg.height;
      end
   end

   // main decode step
   always_comb begin
      dec_state_type     st;
      dec_state_type     nx;
      rsp_item_type      a;
      rsp_item_type      d;
      logic              emit_a;
      logic              emit_d;
      logic              do_end;
      logic              do_pix;
      logic              do_run;
      logic [15:0]       pix_val;
      logic [11:0]       sum_sk;
      logic [COL_W-1:0]  col_sk;
      logic [11:0]       sum_len;
      logic [11:0]       sum_inc;
      logic [COL_W-1:0]  col_inc;
      logic [ADDR_W-1:0] pix_addr;
      logic [ADDR_W-1:0] sh_addr;
      logic [COL_W-1:0]  room;
      logic [7:0]        n_run;
      logic [7:0]        rr_dec;
      logic [15:0]       key;

      st = state_cur;
      if (image_start) begin
         st.phase    = PH_CTRL_LO;
         st.held     = '0;
         st.column   = '0;
         st.row      = '0;
         st.row_base = '0;
         st.run_rem  = '0;
         st.line_end = 1'b0;
         st.finished = 1'b0;
      end
      nx      = st;
      a       = '0;
      d       = '0;
      d.done  = 1'b1;
      emit_a  = 1'b0;
      emit_d  = 1'b0;
      do_end  = 1'b0;
      do_pix  = 1'b0;
      do_run  = 1'b0;
      pix_val = {stream_byte, st.held};
      key     = cfg.pix_fmt ? KEY_RGB565 : KEY_RGB555;

      // saturating column sums
      sum_sk  = {1'b0, st.column} + {5'b0, stream_byte[6:0]};
      col_sk  = sum_sk[11] ? COL_MAX : sum_sk[COL_W-1:0];
      sum_len = {1'b0, col_sk} + {4'b0, st.held};
      sum_inc = {1'b0, st.column} + 12'd1;
      col_inc = sum_inc[11] ? COL_MAX : sum_inc[COL_W-1:0];

      pix_addr = st.row_base + {9'b0, st.column};
      sh_addr  = st.row_base + {9'b0, col_sk};
      room     = eff_w - col_sk;
      n_run    = ({3'b0, st.held} < room) ? st.held : room[7:0];
      rr_dec   = (st.run_rem != '0) ? st.run_rem - 8'd1 : '0;

      if (!st.finished) begin
         if (cfg.mode == MODE_RAW) begin
            // raw copy: low byte held on even phase, pixel on odd phase
            if ((st.phase == PH_CTRL_HI) || (st.phase == PH_PIX_HI)) begin
               do_pix   = 1'b1;
               nx.phase = PH_CTRL_LO;
               if (col_inc >= eff_w) begin
                  do_end = 1'b1;
               end
            end else begin
               nx.held  = stream_byte;
               nx.phase = PH_CTRL_HI;
            end
         end else begin
            case (st.phase)
               PH_CTRL_LO: begin
                  nx.held  = stream_byte;
                  nx.phase = PH_CTRL_HI;
               end
               PH_CTRL_HI: begin
                  nx.column = col_sk;
                  nx.phase  = PH_CTRL_LO;
                  if (cfg.mode == MODE_SHADOW) begin
                     if (st.held != '0) begin
                        emit_a = 1'b1;
                        a.addr = sh_addr;
                        a.pix  = key;
                        if (col_sk >= eff_w) begin
                           a.len = '0;
                           a.ovf = 1'b1;
                        end else begin
                           a.len = n_run;
                           a.ovf = (st.held > n_run);
                        end
                        nx.column = sum_len[11] ? COL_MAX : sum_len[COL_W-1:0];
                     end
                     do_end = stream_byte[7];
                  end else if (st.held != '0) begin
                     nx.run_rem  = st.held;
                     nx.line_end = stream_byte[7];
                     nx.phase    = PH_PIX_LO;
                  end else begin
                     do_end = stream_byte[7];
                  end
               end
               PH_PIX_LO: begin
                  if (cfg.mode == MODE_INDEXED) begin
                     pix_val = {8'b0, stream_byte};
                     do_run  = 1'b1;
                  end else begin
                     nx.held  = stream_byte;
                     nx.phase = PH_PIX_HI;
                  end
               end
               PH_PIX_HI: begin
                  do_run = 1'b1;
               end
               default: begin
                  nx.phase = PH_CTRL_LO;
               end
            endcase
         end

         // one pixel of a run
         if (do_run) begin
            do_pix     = 1'b1;
            nx.run_rem = rr_dec;
            if (rr_dec == '0) begin
               nx.phase = PH_CTRL_LO;
               do_end   = st.line_end;
            end else begin
               nx.phase = PH_PIX_LO;
            end
         end

         // single pixel write, suppressed past the row width
         if (do_pix) begin
            emit_a    = 1'b1;
            a.addr    = pix_addr;
            a.pix     = pix_val;
            a.len     = (st.column < eff_w) ? 8'd1 : 8'd0;
            a.ovf     = !(st.column < eff_w);
            nx.column = col_inc;
         end

         // row end and image done marker
         if (do_end) begin
            nx.column   = '0;
            nx.row_base = st.row_base + {9'b0, eff_w};
            nx.phase    = PH_CTRL_LO;
            nx.run_rem  = '0;
            nx.line_end = 1'b0;
            if (({1'b0, st.row} + 12'd1) >= {1'b0, eff_h}) begin
               nx.finished = 1'b1;
               emit_d      = 1'b1;
            end
            if (st.row != COL_MAX) begin
               nx.row = st.row + 11'd1;
            end
         end
      end

      // order the results, last marks the final one of the byte
      state_nxt = nx;
      res0      = emit_a ? a : d;
      res0.last = !(emit_a && emit_d);
      res1      = d;
      res1.last = 1'b1;
      res_cnt   = {1'b0, emit_a} + {1'b0, emit_d};
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// rsd_rsp_queue: result queue
// Four-entry queue that takes up to two result items per cycle and hands out
// one per beat on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_rsp_queue
   import rsd_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire [1:0]         push_cnt,
   input  wire rsp_item_type push0,
   input  wire rsp_item_type push1,
   output logic              room_ok,
   output logic              out_valid,
   input  wire               out_ready,
   output rsp_item_type      out_item
);

   localparam int DEPTH = 4;

   rsp_item_type mem_ff [DEPTH];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;
   logic [1:0]   wr_ptr_nx1;

   assign out_valid  = (count_ff != '0);
   assign room_ok    = (count_ff <= 3'd2);
   assign pop        = out_valid && out_ready;
   assign out_item   = mem_ff[rd_ptr_ff];
   assign wr_ptr_nx1 = wr_ptr_ff + 2'd1;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_cnt} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nx1] <= push1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_checker.sv =====
// ----------------------------------------------------------------------------
// rsd_checker: port-level checks for the sprite row decoder
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire [1:0]  rsp_tuser,
   input wire        rsp_tlast
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // done marker is an all-zero write closing its byte
   a_done_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[43:0] == 44'd0 && !rsp_tuser[1] && rsp_tlast)
      else $error("malformed done marker");

   // a zero-length write is either the done marker or an overflow
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:20] == 8'd0 && !rsp_tuser[0] |-> rsp_tuser[1])
      else $error("zero-length write without overflow");

endmodule

bind rle_sprite_row_decoder rsd_checker u_rsd_checker (.*);

`default_nettype wire

// ===== sim/rle_sprite_row_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder_tb: self-checking bench for the sprite row decoder
// Streams encoded sprite bytes through all four decode modes and compares
// every write beat against an in-bench decoder. Covers directed corner
// cases, back-pressure, column saturation and a long randomized image mix.
// ----------------------------------------------------------------------------

module rle_sprite_row_decoder_tb;
   import rsd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 1200;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] stream_byte
   logic [0:0]  req_tuser = '0;    // [0] image_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [19:0] addr, [27:20] run, [43:28] pixel, [47:44] zero
   logic [1:0]  rsp_tuser;         // [0] image_done, [1] overflow
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr = '0;
   logic [10:0] csr_data = '0;

   // bench control
   bit          jitter_on = 1'b1;
   int          hold_requests = 0;
   int          holds_taken = 0;
   int          hold_left = 0;
   int          mismatch_count = 0;
   int          decoded_bytes = 0;
   int unsigned cycle_count = 0;

   // decoder mirror: registers and state
   decode_mode_type cfg_mode;
   logic            cfg_fmt;
   logic [10:0]     cfg_width;
   logic [10:0]     cfg_height;
   phase_type       dec_phase;
   logic [7:0]      held_byte;
   logic [10:0]     column;
   logic [10:0]     row;
   logic [19:0]     row_base;
   logic [7:0]      run_left;
   logic            line_end;
   logic            image_finished;

   // frame-buffer writes still owed by the block, oldest first
   rsp_item_type    pending_writes[$];
   rsp_item_type    byte_writes[$];

   rle_sprite_row_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // decoder mirror
   // ------------------------------------------------------------------

   function automatic int width_eff();
      if (cfg_width == 11'd0) return 1;
      if (int'(cfg_width) > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int height_eff();
      if (cfg_height == 11'd0) return 1;
      if (int'(cfg_height) > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   // column counter saturates instead of wrapping
   function automatic logic [10:0] sat_column(logic [10:0] c, int n);
      int s;
      s = int'(c) + n;
      if (s > int'(COL_MAX)) return COL_MAX;
      return 11'(s);
   endfunction

   function automatic void clear_decoder();
      dec_phase      = PH_CTRL_LO;
      held_byte      = '0;
      column         = '0;
      row            = '0;
      row_base       = '0;
      run_left       = '0;
      line_end       = 1'b0;
      image_finished = 1'b0;
   endfunction

   function automatic void add_write(logic [19:0] addr, int len, logic [15:0] pix,
                                     logic done, logic ovf);
      rsp_item_type w;
      w.addr = addr;
      w.len  = 8'(len);
      w.pix  = pix;
      w.done = done;
      w.ovf  = ovf;
      w.last = 1'b0;
      byte_writes.push_back(w);
   endfunction

   // row end: advance base, and flag the image done on the final row
   function automatic void finish_row();
      column    = '0;
      row_base  = row_base + 20'(width_eff());
      dec_phase = PH_CTRL_LO;
      run_left  = '0;
      line_end  = 1'b0;
      if (int'(row) + 1 >= height_eff()) begin
         image_finished = 1'b1;
         add_write('0, 0, '0, 1'b1, 1'b0);
      end
      if (row < COL_MAX) row = row + 11'd1;
   endfunction

   // one pixel, suppressed once the column is past the row width
   function automatic void put_pixel(logic [15:0] pix);
      logic [19:0] addr;
      addr = row_base + 20'(column);
      if (int'(column) < width_eff()) add_write(addr, 1, pix, 1'b0, 1'b0);
      else add_write(addr, 0, pix, 1'b0, 1'b1);
      column = sat_column(column, 1);
   endfunction

   function automatic void run_pixel(logic [15:0] pix);
      put_pixel(pix);
      if (run_left != 8'd0) run_left = run_left - 8'd1;
      if (run_left == 8'd0) begin
         dec_phase = PH_CTRL_LO;
         if (line_end) finish_row();
      end else begin
         dec_phase = PH_PIX_LO;
      end
   endfunction

   // decode one accepted stream byte and queue the writes it causes
   function automatic void decode_byte(logic [7:0] b, logic start);
      int           len;
      int           room;
      int           n;
      logic         eol;
      logic [15:0]  key;
      logic [19:0]  addr;
      rsp_item_type w;
      byte_writes.delete();
      if (start) clear_decoder();
      if (!image_finished) begin
         decoded_bytes++;
         if (cfg_mode == MODE_RAW) begin
            // raw copy: even phases hold the low byte, odd phases complete a pixel
            if (dec_phase == PH_CTRL_LO || dec_phase == PH_PIX_LO) begin
               held_byte = b;
               dec_phase = PH_CTRL_HI;
            end else begin
               put_pixel({b, held_byte});
               dec_phase = PH_CTRL_LO;
               if (int'(column) >= width_eff()) finish_row();
            end
         end else begin
            case (dec_phase)
               PH_CTRL_LO: begin
                  held_byte = b;
                  dec_phase = PH_CTRL_HI;
               end
               PH_CTRL_HI: begin
                  len    = int'(held_byte);
                  eol    = b[7];
                  column = sat_column(column, int'(b[6:0]));
                  if (cfg_mode == MODE_SHADOW) begin
                     // key fill clipped at the row width
                     if (len > 0) begin
                        key  = cfg_fmt ? KEY_RGB565 : KEY_RGB555;
                        addr = row_base + 20'(column);
                        if (int'(column) >= width_eff()) begin
                           add_write(addr, 0, key, 1'b0, 1'b1);
                        end else begin
                           room = width_eff() - int'(column);
                           n    = (len < room) ? len : room;
                           add_write(addr, n, key, 1'b0, len > n);
                        end
                        column = sat_column(column, len);
                     end
                     dec_phase = PH_CTRL_LO;
                     if (eol) finish_row();
                  end else if (len > 0) begin
                     run_left  = 8'(len);
                     line_end  = eol;
                     dec_phase = PH_PIX_LO;
                  end else begin
                     dec_phase = PH_CTRL_LO;
                     if (eol) finish_row();
                  end
               end
               PH_PIX_LO: begin
                  if (cfg_mode == MODE_INDEXED) begin
                     run_pixel({8'h00, b});
                  end else begin
                     held_byte = b;
                     dec_phase = PH_PIX_HI;
                  end
               end
               default: run_pixel({b, held_byte});
            endcase
         end
      end
      foreach (byte_writes[i]) begin
         w      = byte_writes[i];
         w.last = (i == byte_writes.size() - 1);
         pending_writes.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------
   // write beat checking and receiver stalls
   // ------------------------------------------------------------------

   function automatic void check_write_beat();
      rsp_item_type got;
      rsp_item_type want;
      got.addr = rsp_tdata[19:0];
      got.len  = rsp_tdata[27:20];
      got.pix  = rsp_tdata[43:28];
      got.done = rsp_tuser[0];
      got.ovf  = rsp_tuser[1];
      got.last = rsp_tlast;
      if (pending_writes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected write beat: addr %h len %0d pix %h done %b ovf %b last %b",
                     got.addr, got.len, got.pix, got.done, got.ovf, got.last);
      end else begin
         want = pending_writes.pop_front();
         if (got.addr !== want.addr || got.len !== want.len || got.pix !== want.pix ||
             got.done !== want.done || got.ovf !== want.ovf || got.last !== want.last ||
             rsp_tdata[47:44] !== 4'h0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("write beat mismatch: expected addr %h len %0d pix %h done %b ovf %b last %b",
                        want.addr, want.len, want.pix, want.done, want.ovf, want.last);
               $display("                     got      addr %h len %0d pix %h done %b ovf %b last %b pad %h",
                        got.addr, got.len, got.pix, got.done, got.ovf, got.last,
                        rsp_tdata[47:44]);
            end
         end
      end
   endfunction

   // receiver: check accepted beats, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_write_beat();
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (jitter_on) begin
         rsp_tready <= ($urandom_range(0, 99) >= 25);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rle_sprite_row_decoder] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // offer one stream byte, with random gaps when jitter is on
   task automatic push_byte(logic [7:0] b, logic start);
      if (jitter_on)
         while ($urandom_range(0, 99) < 25) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, start);
   endtask

   // stop sending and let every owed write drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DECODE_MODE:  cfg_mode = decode_mode_type'(value[1:0]);
         CSR_PIXEL_FORMAT: cfg_fmt = value[0];
         CSR_IMAGE_WIDTH:  cfg_width = value;
         default:          cfg_height = value;
      endcase
   endtask

   task automatic configure(decode_mode_type mode, logic fmt, logic [10:0] w, logic [10:0] h);
      write_reg(CSR_DECODE_MODE, 11'(mode));
      write_reg(CSR_PIXEL_FORMAT, 11'(fmt));
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [10:0] pick_width();
      case ($urandom_range(0, 11))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd1024;
         3:       return 11'd2047;
         4:       return 11'($urandom_range(1025, 2046));
         default: return 11'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [10:0] pick_height();
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd2047;
         default: return 11'($urandom_range(1, 4));
      endcase
   endfunction

   // rewrite a random subset of registers, sometimes with junk upper bits
   task automatic retune_registers();
      logic [10:0] value;
      if ($urandom_range(0, 1)) begin
         value = 11'($urandom_range(0, 3));
         if ($urandom_range(0, 7) == 0) value[10:2] = 9'($urandom);
         write_reg(CSR_DECODE_MODE, value);
      end
      if ($urandom_range(0, 1)) begin
         value = 11'($urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) value[10:1] = 10'($urandom);
         write_reg(CSR_PIXEL_FORMAT, value);
      end
      if ($urandom_range(0, 1)) write_reg(CSR_IMAGE_WIDTH, pick_width());
      if ($urandom_range(0, 1)) write_reg(CSR_IMAGE_HEIGHT, pick_height());
      csr_valid <= 1'b0;
   endtask

   // mostly short runs, now and then empty or very long ones
   function automatic int pick_run();
      int r;
      int top;
      r   = $urandom_range(0, 39);
      top = (width_eff() < 12) ? width_eff() + 2 : 14;
      if (r == 0) return 255;
      if (r == 1) return $urandom_range(16, 128);
      if (r < 6) return 0;
      return $urandom_range(1, top);
   endfunction

   function automatic logic [6:0] pick_skip();
      case ($urandom_range(0, 9))
         0:       return 7'd127;
         1:       return 7'($urandom_range(0, 127));
         2, 3, 4: return 7'd0;
         default: return 7'($urandom_range(0, 3));
      endcase
   endfunction

   // well-formed image under the current mode with random content
   task automatic send_image(logic with_start);
      int   nbytes;
      int   rows;
      int   words;
      int   len;
      int   npix;
      logic first;
      first = with_start;
      if (cfg_mode == MODE_RAW) begin
         nbytes = width_eff() * height_eff() * 2;
         if (nbytes > 96) nbytes = $urandom_range(8, 96);
         for (int i = 0; i < nbytes; i++) begin
            push_byte(8'($urandom), first);
            first = 1'b0;
         end
      end else begin
         rows = (height_eff() < 5) ? height_eff() : 5;
         for (int r = 0; r < rows; r++) begin
            words = $urandom_range(1, 3);
            for (int k = 0; k < words; k++) begin
               len = pick_run();
               push_byte(8'(len), first);
               first = 1'b0;
               push_byte({k == words - 1, pick_skip()}, 1'b0);
               npix = 0;
               if (cfg_mode == MODE_INDEXED) npix = len;
               else if (cfg_mode == MODE_COLOR16) npix = 2 * len;
               for (int p = 0; p < npix; p++) push_byte(8'($urandom), 1'b0);
            end
         end
      end
   endtask

   // raw noise with the odd restart
   task automatic send_noise();
      int n;
      n = $urandom_range(4, 24);
      for (int i = 0; i < n; i++)
         push_byte(8'($urandom), $urandom_range(0, 15) == 0);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // indexed runs with skip, overflow and row end, then a color16 pixel
   task automatic test_directed_runs();
      configure(MODE_INDEXED, 1'b0, 11'd4, 11'd2);
      push_byte(8'h04, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7f, 1'b0);
      // skip-only word that ends the first row
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      // pixel far past the width, then the done marker from the same byte
      push_byte(8'h01, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'ha5, 1'b0);
      // ignored after done
      push_byte(8'h12, 1'b0);
      wait_idle();
      // width and height clamped from the out-of-range extremes
      configure(MODE_COLOR16, 1'b0, 11'd2047, 11'd0);
      push_byte(8'h01, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      wait_idle();
   endtask

   // shadow runs crossing and starting past the width, and an empty run
   task automatic test_directed_shadow();
      configure(MODE_SHADOW, 1'b1, 11'd6, 11'd2047);
      push_byte(8'h04, 1'b1);
      push_byte(8'h03, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h05, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h80, 1'b0);
      wait_idle();
   endtask

   // raw copy ending the image on its last pixel
   task automatic test_directed_raw();
      configure(MODE_RAW, 1'b0, 11'd2, 11'd1);
      push_byte(8'h34, 1'b1);
      push_byte(8'h12, 1'b0);
      push_byte(8'hcd, 1'b0);
      push_byte(8'hab, 1'b0);
      wait_idle();
   endtask

   // receiver stalls for a long stretch while shadow words keep coming
   task automatic test_backpressure();
      configure(MODE_SHADOW, 1'b0, 11'd8, 11'd2047);
      jitter_on = 1'b0;
      hold_requests++;
      push_byte(8'h03, 1'b1);
      push_byte(8'h00, 1'b0);
      for (int i = 0; i < 40; i++) begin
         push_byte(8'($urandom_range(1, 9)), 1'b0);
         push_byte({$urandom_range(0, 3) == 0, 7'($urandom_range(0, 2))}, 1'b0);
      end
      wait_idle();
      jitter_on = 1'b1;
   endtask

   // full-width rows: column saturation and a pixel written far past the width
   task automatic test_column_saturation();
      configure(MODE_COLOR16, 1'b0, 11'd1024, 11'd1024);
      jitter_on = 1'b0;
      for (int r = 0; r < 8; r++) begin
         push_byte(8'h00, r == 0);
         push_byte(8'h80, 1'b0);
      end
      push_byte(8'h02, 1'b0);
      push_byte(8'h7f, 1'b0);
      for (int i = 0; i < 4; i++) push_byte(8'($urandom), 1'b0);
      for (int i = 0; i < 16; i++) begin
         push_byte(8'h00, 1'b0);
         push_byte(8'h7f, 1'b0);
      end
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b0);
      wait_idle();
      jitter_on = 1'b1;
   endtask

   // random images and noise across register settings
   task automatic test_random();
      int target;
      int phase_no;
      target   = decoded_bytes + RANDOM_BYTES;
      phase_no = 0;
      while (decoded_bytes < target) begin
         wait_idle();
         jitter_on = !(phase_no >= 20 && phase_no < 35);
         if (phase_no == 0 || $urandom_range(0, 2) != 0) retune_registers();
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_image($urandom_range(0, 7) != 0);
         phase_no++;
      end
      wait_idle();
      jitter_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      cfg_mode   = MODE_COLOR16;
      cfg_fmt    = 1'b0;
      cfg_width  = 11'd1;
      cfg_height = 11'd1;
      clear_decoder();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_runs();
      test_directed_shadow();
      test_directed_raw();
      test_backpressure();
      test_column_saturation();
      test_random();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0)
         $display("[rle_sprite_row_decoder] OK");
      else
         $display("[rle_sprite_row_decoder] ERROR");
      $finish;
   end

endmodule
